FILE: rtl/sehc_pkg.sv
// ----------------------------------------------------------------------------
// sehc_pkg
// Shared types, codes and constants of the strip earliest-hit coincidence
// block.
// ----------------------------------------------------------------------------
package sehc_pkg;

    localparam int DETECTOR_COUNT    = 5;
    localparam int LANES             = DETECTOR_COUNT * 2;
    localparam int LANE_BITS         = 4;
    localparam int STRIP_COUNT_DEF   = 64;
    localparam int TIME_BITS_DEF     = 20;

    // item kinds carried on tuser
    localparam logic [1:0] KIND_OFFSET = 2'd0;
    localparam logic [1:0] KIND_STRIP  = 2'd1;
    localparam logic [1:0] KIND_EOE    = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_ENERGY_THRESHOLD   = 3'd0;
    localparam logic [2:0] REG_TIME_FLOOR         = 3'd1;
    localparam logic [2:0] REG_TIME_CEILING       = 3'd2;
    localparam logic [2:0] REG_COINCIDENCE_WINDOW = 3'd3;
    localparam logic [2:0] REG_GATE_LIMIT         = 3'd4;

    // configuration reset values
    localparam logic [15:0]        RST_ENERGY_THRESHOLD   = 16'd4000;
    localparam logic signed [19:0] RST_TIME_FLOOR         = -20'sd5000;
    localparam logic signed [19:0] RST_TIME_CEILING       = 20'sd150;
    localparam logic [18:0]        RST_COINCIDENCE_WINDOW = 19'd150;
    localparam logic [19:0]        RST_GATE_LIMIT         = 20'd50000;

    typedef struct packed {
        logic [1:0]         kind;
        logic [2:0]         detector;
        logic               axis;
        logic [5:0]         strip;
        logic signed [19:0] time_value;
        logic [15:0]        energy;
        logic [19:0]        gate_value;
    } item_t;

    typedef struct packed {
        logic [15:0]        energy_threshold;
        logic signed [19:0] time_floor;
        logic signed [19:0] time_ceiling;
        logic [18:0]        coincidence_window;
        logic [19:0]        gate_limit;
    } cfg_t;

    // end-of-event handoff from the lane unit to the emitter
    typedef struct packed {
        logic             load;
        logic [LANES-1:0] mask;
    } snap_t;

endpackage

FILE: rtl/sehc_offset_ram.sv
// ----------------------------------------------------------------------------
// sehc_offset_ram
// Per-strip time offset memory: one write port, one registered read port,
// and a zero-fill sweep after reset.
// ----------------------------------------------------------------------------
module sehc_offset_ram #(
    parameter int   STRIP_COUNT = sehc_pkg::STRIP_COUNT_DEF,
    localparam int  DEPTH       = sehc_pkg::LANES * STRIP_COUNT,
    localparam int  ADDR_W      = $clog2(DEPTH)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [sehc_pkg::LANE_BITS-1:0]    wr_lane,
    input  logic [5:0]                        wr_strip,
    input  logic signed [19:0]                wr_data,
    input  logic                              rd_en,
    input  logic [sehc_pkg::LANE_BITS-1:0]    rd_lane,
    input  logic [5:0]                        rd_strip,
    output logic signed [19:0]                rd_data,
    output logic                              ready
);

    logic signed [19:0] mem [DEPTH];
    logic [ADDR_W-1:0]  clr_addr_reg;
    logic [ADDR_W-1:0]  clr_addr_next;
    logic               clr_busy_reg;
    logic               clr_busy_next;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  mem_addr;
    logic signed [19:0] mem_wdata;
    logic               mem_we;
    logic signed [19:0] rd_data_reg;

    always_comb
    begin
        wr_addr = ADDR_W'(wr_lane) * ADDR_W'(STRIP_COUNT) + ADDR_W'(wr_strip);
        rd_addr = ADDR_W'(rd_lane) * ADDR_W'(STRIP_COUNT) + ADDR_W'(rd_strip);
        // sweep owns the write port until every entry holds zero
        mem_we    = clr_busy_reg | wr_en;
        mem_addr  = clr_busy_reg ? clr_addr_reg : wr_addr;
        mem_wdata = clr_busy_reg ? 20'sd0 : wr_data;
        clr_addr_next = clr_addr_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign ready   = ~clr_busy_reg;

endmodule

FILE: rtl/sehc_lane_unit.sv
// ----------------------------------------------------------------------------
// sehc_lane_unit
// Offset correction, qualification and earliest-strip tracking per detector
// and axis; builds the coincidence mask at end of event.
// ----------------------------------------------------------------------------
module sehc_lane_unit #(
    parameter int TIME_BITS = sehc_pkg::TIME_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sehc_pkg::item_t              item,
    input  logic                         item_valid,
    input  logic                         item_ok,
    input  logic signed [19:0]           offset,
    input  sehc_pkg::cfg_t               cfg,
    input  logic                         emit_busy,
    output sehc_pkg::snap_t              snap,
    output logic [5:0]                   snap_strip [sehc_pkg::LANES],
    output logic signed [TIME_BITS-1:0]  snap_time [sehc_pkg::LANES],
    output logic [sehc_pkg::LANES-1:0]   lane_valid
);

    localparam int CW = ((TIME_BITS > 21) ? TIME_BITS : 21) + 1;
    localparam int AW = ((TIME_BITS + 1 > 19) ? TIME_BITS + 1 : 19) + 1;
    localparam logic signed [CW-1:0] T_HI = CW'((64'd1 << (TIME_BITS - 1)) - 64'd1);
    localparam logic signed [CW-1:0] T_LO = -T_HI - CW'(1);

    logic [sehc_pkg::LANES-1:0]    valid_reg;
    logic [sehc_pkg::LANES-1:0]    valid_next;
    logic [5:0]                    strip_reg [sehc_pkg::LANES];
    logic signed [TIME_BITS-1:0]   time_reg [sehc_pkg::LANES];

    logic [sehc_pkg::LANE_BITS-1:0] lane;
    logic signed [CW-1:0]          diff;
    logic signed [CW-1:0]          t_sat;
    logic signed [TIME_BITS-1:0]   t_new;
    logic                          qualify;
    logic                          better;
    logic                          strip_fire;
    logic                          eoe_fire;
    logic                          update;
    logic                          gate_open;
    logic [sehc_pkg::LANES-1:0]    pass;
    logic [1:0]                    both01;
    logic signed [AW-1:0]          dt;
    logic [AW-1:0]                 adt;
    logic                          near;

    always_comb
    begin
        lane  = {item.detector, item.axis};
        diff  = CW'($signed(item.time_value)) - CW'($signed(offset));
        if (diff > T_HI)
        begin
            t_sat = T_HI;
        end
        else if (diff < T_LO)
        begin
            t_sat = T_LO;
        end
        else
        begin
            t_sat = diff;
        end
        t_new   = t_sat[TIME_BITS-1:0];
        qualify = (item.energy > cfg.energy_threshold)
                  && (t_sat > CW'($signed(cfg.time_floor)))
                  && (t_sat < CW'($signed(cfg.time_ceiling)));
        better  = !valid_reg[lane] || (t_new < time_reg[lane])
                  || ((t_new == time_reg[lane]) && (item.strip < strip_reg[lane]));
        strip_fire = item_valid && item_ok && (item.kind == sehc_pkg::KIND_STRIP);
        eoe_fire   = item_valid && (item.kind == sehc_pkg::KIND_EOE) && !emit_busy;
        update     = strip_fire && qualify && better;

        // coincidence rules, lane index is detector*2 + axis
        pass = '0;
        for (int a = 0; a < 2; a++)
        begin
            dt  = AW'(time_reg[a]) - AW'(time_reg[8 + a]);
            adt = dt[AW-1] ? AW'(-dt) : AW'(dt);
            near = adt < AW'(cfg.coincidence_window);
            both01[a] = valid_reg[a] && valid_reg[2 + a];
            pass[a]     = valid_reg[0] && valid_reg[1];
            pass[2 + a] = valid_reg[2] && valid_reg[3];
            pass[4 + a] = valid_reg[4] && valid_reg[5] && both01[a]
                          && (strip_reg[a] == strip_reg[4 + a]);
            pass[6 + a] = valid_reg[6] && valid_reg[7] && both01[a] && valid_reg[4 + a]
                          && (strip_reg[a] == strip_reg[6 + a]);
            pass[8 + a] = valid_reg[8] && valid_reg[9] && valid_reg[a] && valid_reg[6 + a]
                          && (strip_reg[a] == strip_reg[6 + a]) && near;
        end
        gate_open = item.gate_value < cfg.gate_limit;
        snap.load = eoe_fire;
        snap.mask = gate_open ? pass : '0;

        valid_next = valid_reg;
        if (eoe_fire)
        begin
            valid_next = '0;
        end
        else if (update)
        begin
            valid_next[lane] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (update)
        begin
            strip_reg[lane] <= item.strip;
            time_reg[lane]  <= t_new;
        end
    end

    assign snap_strip = strip_reg;
    assign snap_time  = time_reg;
    assign lane_valid = valid_reg;

endmodule

FILE: rtl/sehc_emitter.sv
// ----------------------------------------------------------------------------
// sehc_emitter
// Holds one event's selection and sends its fill records in lane order
// through the output register.
// ----------------------------------------------------------------------------
module sehc_emitter #(
    parameter int TIME_BITS = sehc_pkg::TIME_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sehc_pkg::snap_t              snap,
    input  logic [5:0]                   snap_strip [sehc_pkg::LANES],
    input  logic signed [TIME_BITS-1:0]  snap_time [sehc_pkg::LANES],
    output logic                         busy,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic                         m_tlast,
    output logic [2:0]                   hit_detector,
    output logic                         hit_axis,
    output logic [5:0]                   hit_strip,
    output logic signed [19:0]           hit_time
);

    localparam int HW = (TIME_BITS > 20) ? TIME_BITS : 20;

    logic [sehc_pkg::LANES-1:0]     mask_reg;
    logic [sehc_pkg::LANES-1:0]     mask_next;
    logic [5:0]                     strip_hold [sehc_pkg::LANES];
    logic signed [TIME_BITS-1:0]    time_hold [sehc_pkg::LANES];
    logic                           m_tvalid_reg;
    logic                           m_tvalid_next;
    logic                           m_tlast_reg;
    logic [2:0]                     det_reg;
    logic                           axis_reg;
    logic [5:0]                     strip_reg;
    logic signed [19:0]             time_reg;

    logic [sehc_pkg::LANE_BITS-1:0] sel;
    logic [sehc_pkg::LANES-1:0]     rest;
    logic                           advance;
    logic signed [HW-1:0]           time_ext;

    always_comb
    begin
        sel = '0;
        for (int i = sehc_pkg::LANES - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                sel = sehc_pkg::LANE_BITS'(i);
            end
        end
        rest     = mask_reg & ~(sehc_pkg::LANES'(1) << sel);
        advance  = (|mask_reg) && (!m_tvalid_reg || m_tready);
        time_ext = HW'(time_hold[sel]);

        mask_next = mask_reg;
        if (snap.load)
        begin
            mask_next = snap.mask;
        end
        else if (advance)
        begin
            mask_next = rest;
        end

        m_tvalid_next = m_tvalid_reg;
        if (advance)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            mask_reg     <= mask_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap.load)
        begin
            strip_hold <= snap_strip;
            time_hold  <= snap_time;
        end
        if (advance)
        begin
            det_reg     <= sel[3:1];
            axis_reg    <= sel[0];
            strip_reg   <= strip_hold[sel];
            time_reg    <= time_ext[19:0];
            m_tlast_reg <= (rest == '0);
        end
    end

    assign busy         = |mask_reg;
    assign m_tvalid     = m_tvalid_reg;
    assign m_tlast      = m_tlast_reg;
    assign hit_detector = det_reg;
    assign hit_axis     = axis_reg;
    assign hit_strip    = strip_reg;
    assign hit_time     = time_reg;

endmodule

FILE: rtl/strip_earliest_hit_coincidence.sv
// ----------------------------------------------------------------------------
// strip_earliest_hit_coincidence
// Earliest-hit selection with layer coincidence for five strip detectors.
// ----------------------------------------------------------------------------
// Input stream (s_*): tuser carries the item kind (offset write, strip
// reading, end of event), tdata the remaining fields. One transfer per clock
// is taken while s_tready is high; offset writes go straight to the offset
// memory, strip readings read it, then update the per-lane earliest strip.
// Output stream (m_*): one fill record per transfer, tlast on the last
// record of an event. The first record follows the end-of-event item via the
// pipeline register, record store and output register; the rest follow one
// per cycle while m_tready is high. An event that yields no record produces
// no transfer. A new end-of-event item waits in the pipeline register, with
// s_tready low, until the previous event's records have all left the record
// store; no item is taken meanwhile. Strip readings of the next event do
// flow while records drain, up to that event's own end-of-event item. When
// m_tready is low the output register holds and emission pauses.
// Throughput: one item per cycle outside that wait and the reset sweep, set
// by the one offset memory access and the one lane update per item.
// Reset: configuration registers take their defaults and the offset memory
// is swept to zero, one entry per cycle over all 10 * STRIP_COUNT entries
// (640 by default), with s_tready low. Configuration writes are taken
// during the sweep.
// ----------------------------------------------------------------------------
module strip_earliest_hit_coincidence #(
    parameter int STRIP_COUNT = sehc_pkg::STRIP_COUNT_DEF,
    parameter int TIME_BITS   = sehc_pkg::TIME_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: detector[2:0], axis[3], strip[9:4], time_value[29:10],
    //        energy[45:30], gate_value[65:46], zero fill [71:66]
    input  logic [71:0] s_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]  s_tuser,
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: hit_detector[2:0], hit_axis[3], hit_strip[9:4], hit_time[29:10],
    //        zero fill [31:30]
    output logic [31:0] m_tdata,
    output logic        m_tlast
);

    sehc_pkg::cfg_t   cfg_reg;
    sehc_pkg::cfg_t   cfg_next;
    sehc_pkg::item_t  in_item;
    sehc_pkg::item_t  p1_reg;
    logic             p1_valid_reg;
    logic             p1_valid_next;
    logic             p1_ok_reg;
    logic             in_ok;
    logic             accept;
    logic             stall;
    logic             ram_ready;
    logic signed [19:0] offset;
    logic             emit_busy;
    sehc_pkg::snap_t  snap;
    logic [5:0]       snap_strip [sehc_pkg::LANES];
    logic signed [TIME_BITS-1:0] snap_time [sehc_pkg::LANES];
    logic [sehc_pkg::LANES-1:0]  lane_valid;
    logic [sehc_pkg::LANE_BITS-1:0] in_lane;
    logic [2:0]       hit_detector;
    logic             hit_axis;
    logic [5:0]       hit_strip;
    logic signed [19:0] hit_time;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                sehc_pkg::REG_ENERGY_THRESHOLD:   cfg_next.energy_threshold = cfg_data[15:0];
                sehc_pkg::REG_TIME_FLOOR:         cfg_next.time_floor = cfg_data;
                sehc_pkg::REG_TIME_CEILING:       cfg_next.time_ceiling = cfg_data;
                sehc_pkg::REG_COINCIDENCE_WINDOW: cfg_next.coincidence_window = cfg_data[18:0];
                sehc_pkg::REG_GATE_LIMIT:         cfg_next.gate_limit = cfg_data;
                default:                          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.energy_threshold   <= sehc_pkg::RST_ENERGY_THRESHOLD;
            cfg_reg.time_floor         <= sehc_pkg::RST_TIME_FLOOR;
            cfg_reg.time_ceiling       <= sehc_pkg::RST_TIME_CEILING;
            cfg_reg.coincidence_window <= sehc_pkg::RST_COINCIDENCE_WINDOW;
            cfg_reg.gate_limit         <= sehc_pkg::RST_GATE_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // input unpack and acceptance
    always_comb
    begin
        in_item.kind       = s_tuser;
        in_item.detector   = s_tdata[2:0];
        in_item.axis       = s_tdata[3];
        in_item.strip      = s_tdata[9:4];
        in_item.time_value = s_tdata[29:10];
        in_item.energy     = s_tdata[45:30];
        in_item.gate_value = s_tdata[65:46];
        in_lane  = {in_item.detector, in_item.axis};
        in_ok    = (32'(in_item.detector) < sehc_pkg::DETECTOR_COUNT)
                   && (32'(in_item.strip) < STRIP_COUNT);
        // hold an end-of-event item until the record store has drained
        stall    = p1_valid_reg && (p1_reg.kind == sehc_pkg::KIND_EOE) && emit_busy;
        s_tready = ram_ready && !stall;
        accept   = s_tvalid && s_tready;

        p1_valid_next = stall ? p1_valid_reg : accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= p1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_reg    <= in_item;
            p1_ok_reg <= in_ok;
        end
    end

    sehc_offset_ram #(
        .STRIP_COUNT (STRIP_COUNT)
    ) u_offset_ram (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept && in_ok && (in_item.kind == sehc_pkg::KIND_OFFSET)),
        .wr_lane  (in_lane),
        .wr_strip (in_item.strip),
        .wr_data  (in_item.time_value),
        .rd_en    (accept && in_ok && (in_item.kind == sehc_pkg::KIND_STRIP)),
        .rd_lane  (in_lane),
        .rd_strip (in_item.strip),
        .rd_data  (offset),
        .ready    (ram_ready)
    );

    sehc_lane_unit #(
        .TIME_BITS (TIME_BITS)
    ) u_lane_unit (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (p1_reg),
        .item_valid (p1_valid_reg),
        .item_ok    (p1_ok_reg),
        .offset     (offset),
        .cfg        (cfg_reg),
        .emit_busy  (emit_busy),
        .snap       (snap),
        .snap_strip (snap_strip),
        .snap_time  (snap_time),
        .lane_valid (lane_valid)
    );

    sehc_emitter #(
        .TIME_BITS (TIME_BITS)
    ) u_emitter (
        .clk          (clk),
        .rst_n        (rst_n),
        .snap         (snap),
        .snap_strip   (snap_strip),
        .snap_time    (snap_time),
        .busy         (emit_busy),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tlast      (m_tlast),
        .hit_detector (hit_detector),
        .hit_axis     (hit_axis),
        .hit_strip    (hit_strip),
        .hit_time     (hit_time)
    );

    assign m_tdata = {2'b00, hit_time, hit_strip, hit_axis, hit_detector};

`ifndef NO_ASSERTIONS
    a_eoe_held: assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> (p1_valid_reg && (p1_reg.kind == sehc_pkg::KIND_EOE)))
        else $error("end-of-event item lost while record store busy");

    a_snap_idle: assert property (@(posedge clk) disable iff (!rst_n)
        snap.load |-> !emit_busy)
        else $error("event snapshot loaded over pending records");

    a_lanes_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        snap.load |=> (lane_valid == '0))
        else $error("lane selection not cleared after end of event");

    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        !ram_ready |-> !p1_valid_next)
        else $error("item accepted during offset memory sweep");
`endif

endmodule
